// ===== design/stfs_pkg.sv =====
// Shared types and constants for the session table with free-slot stack.
package stfs_pkg;

  localparam int Slots = 64;
  localparam int OrderW = 64;

  typedef enum logic [1:0] {
    CmdLookup  = 2'd0,
    CmdAlloc   = 2'd1,
    CmdRelease = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StScan,
    StWait
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [5:0]  release_slot;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
    logic [6:0] active_count;
  } out_t;

  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [OrderW-1:0] order;
  } scan_t;

  typedef struct packed {
    logic alloc;
    logic release_en;
  } slot_op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

endpackage

// ===== design/stfs_slot_cell.sv =====
// One session slot: stored key and order, plus one stage of the lookup scan chain.
module stfs_slot_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stfs_pkg::slot_op_t          op_i,
  input  logic [IW-1:0]               wr_idx_i,
  input  logic [31:0]                 wr_addr_i,
  input  logic [15:0]                 wr_port_i,
  input  logic [stfs_pkg::OrderW-1:0] wr_order_i,
  input  logic [31:0]                 key_addr_i,
  input  logic [15:0]                 key_port_i,
  input  stfs_pkg::scan_t             scan_i,
  input  logic [IW-1:0]               best_i,
  output stfs_pkg::scan_t             scan_o,
  output logic [IW-1:0]               best_o,
  output logic                        valid_o
);

  logic                        valid_q, valid_d;
  logic [31:0]                 addr_q;
  logic [15:0]                 port_q;
  logic [stfs_pkg::OrderW-1:0] order_q;
  logic                        tok_q;
  logic                        hit_q;
  logic [stfs_pkg::OrderW-1:0] best_order_q;
  logic [IW-1:0]               best_q;
  logic                        sel;
  logic                        match;

  assign sel = (wr_idx_i == IW'(IDX));

  always_comb begin
    valid_d = valid_q;
    if (op_i.alloc && sel) begin
      valid_d = 1'b1;
    end else if (op_i.release_en && sel) begin
      valid_d = 1'b0;
    end
  end

  assign match = valid_q && (addr_q == key_addr_i) && (port_q == key_port_i) &&
                 (!scan_i.hit || (order_q < scan_i.order));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= scan_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.alloc && sel) begin
      addr_q  <= wr_addr_i;
      port_q  <= wr_port_i;
      order_q <= wr_order_i;
    end
    if (match) begin
      hit_q        <= 1'b1;
      best_order_q <= order_q;
      best_q       <= IW'(IDX);
    end else begin
      hit_q        <= scan_i.hit;
      best_order_q <= scan_i.order;
      best_q       <= best_i;
    end
  end

  assign scan_o.tok   = tok_q;
  assign scan_o.hit   = hit_q;
  assign scan_o.order = best_order_q;
  assign best_o       = best_q;
  assign valid_o      = valid_q;

endmodule

// ===== design/stfs_stack_cell.sv =====
// One entry of the shifting free-slot stack.
module stfs_stack_cell #(
  parameter int IW   = 6,
  parameter int INIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stfs_pkg::stk_op_t  op_i,
  input  logic [IW-1:0]      above_i,
  input  logic [IW-1:0]      below_i,
  output logic [IW-1:0]      entry_o
);

  logic [IW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (op_i.push) begin
      entry_d = above_i;
    end else if (op_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= IW'(INIT);
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== design/session_table_with_free_slot_stack_core.sv =====
// Session table with free-slot stack: top level with control and cell chains.
//
// A table of SLOTS sessions keyed by address and port. Allocate takes the slot on top
// of a free stack (slot 0 first after reset), release returns a slot by index, and
// lookup returns the earliest-allocated valid slot matching the key. One word is
// worked on at a time. Allocate, release and an unused command go from accept through
// the execute and wait states back to idle; lookup also waits in the scan state until
// the search token, walking the chain of slot cells one cell per cycle, leaves the last
// cell. Either stalls in the wait state while an earlier result sits untaken in the
// output register, which lets a new word be accepted while a result is not yet taken.
module session_table_with_free_slot_stack_core #(
  parameter int SLOTS = stfs_pkg::Slots
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stfs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stfs_pkg::out_t out_data_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  stfs_pkg::state_e            state_q, state_d;
  stfs_pkg::in_t               cmd_q;
  logic [CW-1:0]               free_q, free_d;
  logic [stfs_pkg::OrderW-1:0] seq_q, seq_d;
  logic [1:0]                  res_status_q, res_status_d;
  logic [IW-1:0]               res_slot_q, res_slot_d;
  logic                        out_valid_q, out_valid_d;
  stfs_pkg::out_t              out_q;
  logic                        load_out;
  logic                        launch;

  stfs_pkg::slot_op_t          slot_op;
  stfs_pkg::stk_op_t           stk_op;
  logic [IW-1:0]               wr_idx;
  logic [IW-1:0]               rel_idx;
  logic                        rel_in_range;
  logic [SLOTS-1:0]            valid_vec;
  logic [IW-1:0]               stk [SLOTS];
  stfs_pkg::scan_t             chain [SLOTS+1];
  logic [IW-1:0]               best_chain [SLOTS+1];

  assign rel_idx      = IW'(cmd_q.release_slot);
  assign rel_in_range = (32'(cmd_q.release_slot) < 32'(SLOTS));

  assign chain[0].tok   = launch;
  assign chain[0].hit   = 1'b0;
  assign chain[0].order = '0;
  assign best_chain[0]  = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    stfs_slot_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (slot_op),
      .wr_idx_i   (wr_idx),
      .wr_addr_i  (cmd_q.client_addr),
      .wr_port_i  (cmd_q.client_port),
      .wr_order_i (seq_q),
      .key_addr_i (cmd_q.client_addr),
      .key_port_i (cmd_q.client_port),
      .scan_i     (chain[k]),
      .best_i     (best_chain[k]),
      .scan_o     (chain[k+1]),
      .best_o     (best_chain[k+1]),
      .valid_o    (valid_vec[k])
    );
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_stk
    logic [IW-1:0] above;
    logic [IW-1:0] below;
    if (j == 0) begin : g_top
      assign above = rel_idx;
    end else begin : g_mid
      assign above = stk[j-1];
    end
    if (j == SLOTS - 1) begin : g_bot
      assign below = stk[j];
    end else begin : g_up
      assign below = stk[j+1];
    end
    stfs_stack_cell #(
      .IW   (IW),
      .INIT (j)
    ) u_stk (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (stk_op),
      .above_i (above),
      .below_i (below),
      .entry_o (stk[j])
    );
  end

  always_comb begin
    state_d      = state_q;
    free_d       = free_q;
    seq_d        = seq_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    slot_op      = '0;
    stk_op       = '0;
    wr_idx       = rel_idx;
    launch       = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      stfs_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = stfs_pkg::StExec;
        end
      end
      stfs_pkg::StExec: begin
        state_d      = stfs_pkg::StWait;
        res_status_d = stfs_pkg::StatNotFound;
        res_slot_d   = '0;
        case (cmd_q.command)
          stfs_pkg::CmdLookup: begin
            launch  = 1'b1;
            state_d = stfs_pkg::StScan;
          end
          stfs_pkg::CmdAlloc: begin
            if (free_q == '0) begin
              res_status_d = stfs_pkg::StatFull;
            end else begin
              wr_idx        = stk[0];
              slot_op.alloc = 1'b1;
              stk_op.pop    = 1'b1;
              free_d        = free_q - CW'(1);
              seq_d         = seq_q + stfs_pkg::OrderW'(1);
              res_status_d  = stfs_pkg::StatOk;
              res_slot_d    = stk[0];
            end
          end
          stfs_pkg::CmdRelease: begin
            if (rel_in_range && valid_vec[rel_idx] && (free_q < CW'(SLOTS))) begin
              slot_op.release_en = 1'b1;
              stk_op.push        = 1'b1;
              free_d             = free_q + CW'(1);
              res_status_d       = stfs_pkg::StatOk;
              res_slot_d         = rel_idx;
            end
          end
          default: begin
          end
        endcase
      end
      stfs_pkg::StScan: begin
        if (chain[SLOTS].tok) begin
          state_d = stfs_pkg::StWait;
          if (chain[SLOTS].hit) begin
            res_status_d = stfs_pkg::StatOk;
            res_slot_d   = best_chain[SLOTS];
          end else begin
            res_status_d = stfs_pkg::StatNotFound;
            res_slot_d   = '0;
          end
        end
      end
      stfs_pkg::StWait: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = stfs_pkg::StIdle;
        end
      end
      default: begin
        state_d = stfs_pkg::StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == stfs_pkg::StIdle);
  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stfs_pkg::StIdle;
      free_q      <= CW'(SLOTS);
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (load_out) begin
      out_q.status       <= res_status_q;
      out_q.slot         <= 6'(res_slot_q);
      out_q.active_count <= 7'(CW'(SLOTS) - free_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
